// ===== hdl/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants of the sorted list engine
// Command and status codes, the cell control word and the field widths.
// ----------------------------------------------------------------------------
package sle_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int VALUE_W   = 32;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // operation broadcast to every cell in the same cycle
   typedef enum logic [2:0] {
      OP_NONE   = 3'd0,
      OP_INSERT = 3'd1,
      OP_REMOVE = 3'd2,
      OP_CLEAR  = 3'd3,
      OP_ROTATE = 3'd4
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic signed [VALUE_W-1:0] operand;
      logic signed [VALUE_W-1:0] head;
   } cell_ctl_type;

endpackage

// ===== hdl/sle_cell.sv =====
// ----------------------------------------------------------------------------
// sle_cell: one slot of the sorted chain
// Holds one value and its valid bit; shifts toward its neighbors on insert,
// remove and read-out rotation.
// ----------------------------------------------------------------------------
module sle_cell
   import sle_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cell_ctl_type              ctl,
   input  logic signed [VALUE_W-1:0] left_value,
   input  logic                      left_valid,
   input  logic                      left_ge,
   input  logic signed [VALUE_W-1:0] right_value,
   input  logic                      right_valid,
   input  logic                      found,
   output logic signed [VALUE_W-1:0] value,
   output logic                      valid,
   output logic                      ge,
   output logic                      match
);

   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      valid_ff, valid_in;
   logic                      lt;

   // compare the held value against the broadcast operand
   assign lt    = valid_ff && (value_ff < ctl.operand);
   assign ge    = valid_ff && !lt;
   assign match = valid_ff && (value_ff == ctl.operand);

   // pick next contents from the operation and the neighbors
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      case (ctl.op)
         OP_INSERT: begin
            valid_in = left_valid;
            if (lt) begin
               value_in = value_ff;
            end else if (left_ge) begin
               value_in = left_value;
            end else begin
               value_in = ctl.operand;
            end
         end
         OP_REMOVE: begin
            if (found && ge) begin
               value_in = right_value;
               valid_in = right_valid;
            end
         end
         OP_CLEAR: begin
            valid_in = 1'b0;
         end
         OP_ROTATE: begin
            // tail takes the head word, the rest advance one place
            if (valid_ff && !right_valid) begin
               value_in = ctl.head;
            end else begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

// ===== hdl/sle_ctrl.sv =====
// ----------------------------------------------------------------------------
// sle_ctrl: command sequencer of the sorted list engine
// Decodes commands, keeps the entry count, drives the cell chain and holds
// the response word register.
// ----------------------------------------------------------------------------
module sle_ctrl
   import sle_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [CMD_W-1:0]          req_command,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic signed [VALUE_W-1:0] rsp_entry_value,
   output logic [COUNT_W-1:0]        rsp_entry_count,
   output logic                      rsp_last,
   output cell_ctl_type              ctl,
   input  logic signed [VALUE_W-1:0] head_value,
   input  logic                      found
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_READ = 2'b10
   } state_type;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [IW-1:0]             idx_ff, idx_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                status_ff, status_in;
   logic signed [VALUE_W-1:0] entry_ff, entry_in;
   logic [CW-1:0]             rcount_ff, rcount_in;
   logic                      last_ff, last_in;
   logic                      rsp_free;
   logic                      accept;
   logic                      is_last;
   cmd_type                   cmd;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && rsp_free;
   assign accept    = req_valid && req_ready;
   assign cmd       = cmd_type'(req_command);
   assign is_last   = (idx_ff == IW'(count_ff - CW'(1)));

   // decode and sequence
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      entry_in     = entry_ff;
      rcount_in    = rcount_ff;
      last_in      = last_ff;
      ctl.op       = OP_NONE;
      ctl.operand  = req_value;
      ctl.head     = head_value;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               entry_in     = '0;
               last_in      = 1'b1;
               status_in    = ST_OK;
               case (cmd)
                  CMD_INSERT: begin
                     if (count_ff == CW'(DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        ctl.op   = OP_INSERT;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  CMD_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if (!found) begin
                        status_in = ST_NOT_FOUND;
                     end else begin
                        ctl.op   = OP_REMOVE;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  CMD_CLEAR: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        ctl.op   = OP_CLEAR;
                        count_in = '0;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        // words leave one per cycle from the READ state while the response register is free
                        rsp_valid_in = 1'b0;
                        idx_in       = '0;
                        state_in     = S_READ;
                     end
                  end
               endcase
               rcount_in = count_in;
            end
         end
         S_READ: begin
            // emit the head and rotate the chain by one place
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_OK;
               entry_in     = head_value;
               rcount_in    = count_ff;
               last_in      = is_last;
               ctl.op       = OP_ROTATE;
               idx_in       = idx_ff + IW'(1);
               if (is_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      status_ff <= status_in;
      entry_ff  <= entry_in;
      rcount_ff <= rcount_in;
      last_ff   <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_value = entry_ff;
   assign rsp_entry_count = COUNT_W'(rcount_ff);
   assign rsp_last        = last_ff;

endmodule

// ===== hdl/sorted_list_engine.sv =====
// ----------------------------------------------------------------------------
// sorted_list_engine: bounded table of signed values kept in ascending order
// Insert, remove, clear and ordered read-out over a chain of cells.
// ----------------------------------------------------------------------------
// For insert, remove and clear, the request word is accepted, every
// cell compares its value with the broadcast operand and shifts toward its
// neighbor in the same edge, and the single response word is registered.
// A read-out of N entries: the accepting edge moves the sequencer into
// the read state, then one response word follows per cycle unless stalled.
// The chain rotates by one place per word, taking the head out, so after the
// last word the table is back in its original order. Only one command is in
// flight at a time; a new request is taken once the sequencer is idle and
// the response register is free or being drained. A stalled response holds
// the sequencer for as long as the stall lasts. DEPTH sets the number of
// cells; entry_count carries the low five bits of the count.
module sorted_list_engine
   import sle_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [CMD_W-1:0]          req_command,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic signed [VALUE_W-1:0] rsp_entry_value,
   output logic [COUNT_W-1:0]        rsp_entry_count,
   output logic                      rsp_last
);

   cell_ctl_type              ctl;
   logic signed [VALUE_W-1:0] cell_value [DEPTH+1];
   logic                      cell_valid [DEPTH+1];
   logic                      cell_ge    [DEPTH+1];
   logic [DEPTH-1:0]          cell_match;
   logic                      found;

   // boundary on the right end of the chain
   assign cell_value[DEPTH] = '0;
   assign cell_valid[DEPTH] = 1'b0;
   assign cell_ge[DEPTH]    = 1'b0;

   assign found = |cell_match;

   // build the chain of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VALUE_W-1:0] lv;
      logic                      lval;
      logic                      lge;
      if (i == 0) begin : g_head
         assign lv   = '0;
         assign lval = 1'b1;
         assign lge  = 1'b0;
      end else begin : g_body
         assign lv   = cell_value[i-1];
         assign lval = cell_valid[i-1];
         assign lge  = cell_ge[i-1];
      end
      sle_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_value  (lv),
         .left_valid  (lval),
         .left_ge     (lge),
         .right_value (cell_value[i+1]),
         .right_valid (cell_valid[i+1]),
         .found       (found),
         .value       (cell_value[i]),
         .valid       (cell_valid[i]),
         .ge          (cell_ge[i]),
         .match       (cell_match[i])
      );
   end

   sle_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_entry_value (rsp_entry_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last        (rsp_last),
      .ctl             (ctl),
      .head_value      (cell_value[0]),
      .found           (found)
   );

endmodule
